@@ rtl/core/omni_wheel_drive_mixer_assert.svh @@
// ----------------------------------------------------------------------------
// Omni wheel drive mixer assertion macros
// Concurrent assertion shorthands shared by the mixer RTL.
// ----------------------------------------------------------------------------
`ifndef OMNI_WHEEL_DRIVE_MIXER_ASSERT_SVH
`define OMNI_WHEEL_DRIVE_MIXER_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define OWDM_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("owdm: same-cycle implication failed");

// Check that a condition implies another in the next cycle.
`define OWDM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("owdm: next-cycle implication failed");

`endif

@@ rtl/core/owdm_pkg.sv @@
// ----------------------------------------------------------------------------
// Omni wheel drive mixer package
// Widths, register codes, state encoding, sine table and shared helpers.
// ----------------------------------------------------------------------------
package owdm_pkg;

  // Field and datapath widths
  localparam int DUTY_BITS      = 8;
  localparam int TRIG_FRAC_BITS = 15;
  localparam int TABLE_FRAC     = 15;
  localparam int TRIG_W         = TRIG_FRAC_BITS + 1;
  localparam int HEAD_W         = 9;
  localparam int POWER_W        = 8;
  localparam int ROT_W          = 9;
  localparam int WHEEL_W        = 10;
  localparam int PROD_W         = POWER_W + TRIG_W;
  localparam int CNT_W          = $clog2(POWER_W);
  localparam int DUTY_MAX       = (1 << DUTY_BITS) - 1;

  // Sine table rescaling
  localparam int UP_SHIFT   = (TRIG_FRAC_BITS > TABLE_FRAC) ? TRIG_FRAC_BITS - TABLE_FRAC : 0;
  localparam int DOWN_SHIFT = (TRIG_FRAC_BITS < TABLE_FRAC) ? TABLE_FRAC - TRIG_FRAC_BITS : 0;
  localparam int ROUND_ADD  = (1 << DOWN_SHIFT) >> 1;

  // Configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_SPIN_GAIN      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPIN_LIMIT     = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING_GAIN   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPIN_OUT_LIMIT = 8'd3;

  // Angle constants
  localparam logic [HEAD_W-1:0] SPIN_CODE = 9'd500;
  localparam logic [HEAD_W-1:0] DEG_90    = 9'd90;
  localparam logic [HEAD_W-1:0] DEG_180   = 9'd180;
  localparam logic [HEAD_W-1:0] DEG_270   = 9'd270;
  localparam logic [HEAD_W-1:0] DEG_360   = 9'd360;
  localparam logic [HEAD_W-1:0] DEG_405   = 9'd405;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ANGLE,
    ST_TRIG,
    ST_LAUNCH,
    ST_MULDIV,
    ST_SPIN_GO,
    ST_SPIN,
    ST_WHEEL,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [4:0] spin_gain;
    logic [7:0] spin_limit;
    logic [6:0] damping_gain;
    logic [7:0] spin_out_limit;
  } spin_cfg_t;

  typedef struct packed {
    logic              neg;
    logic [TRIG_W-1:0] mag;
  } trig_t;

  typedef struct packed {
    logic [DUTY_BITS-1:0] fwd;
    logic [DUTY_BITS-1:0] rev;
  } duty_pair_t;

  // round(sin(k deg) * 2^15), k = 0..90
  localparam logic [15:0] SINE_Q15 [91] = '{
    16'd0,     16'd572,   16'd1144,  16'd1715,  16'd2286,  16'd2856,  16'd3425,
    16'd3993,  16'd4560,  16'd5126,  16'd5690,  16'd6252,  16'd6813,  16'd7371,
    16'd7927,  16'd8481,  16'd9032,  16'd9580,  16'd10126, 16'd10668, 16'd11207,
    16'd11743, 16'd12275, 16'd12803, 16'd13328, 16'd13848, 16'd14365, 16'd14876,
    16'd15384, 16'd15886, 16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
    16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622, 16'd21063, 16'd21498,
    16'd21926, 16'd22348, 16'd22763, 16'd23170, 16'd23571, 16'd23965, 16'd24351,
    16'd24730, 16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510, 16'd26842,
    16'd27166, 16'd27482, 16'd27789, 16'd28088, 16'd28378, 16'd28660, 16'd28932,
    16'd29197, 16'd29452, 16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
    16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499, 16'd31651, 16'd31795,
    16'd31928, 16'd32052, 16'd32166, 16'd32270, 16'd32365, 16'd32449, 16'd32524,
    16'd32588, 16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763, 16'd32768
  };

  // Quarter-wave sine, rescaled to the working fraction width
  function automatic logic [TRIG_W-1:0] quarter_sine(input logic [6:0] k);
    logic [6:0] kk;
    int         v;
    kk = (k > 7'd90) ? 7'd90 : k;
    v  = int'(SINE_Q15[kk]);
    return TRIG_W'(((v << UP_SHIFT) + ROUND_ADD) >> DOWN_SHIFT);
  endfunction

  // Sine of t degrees (0..359) as sign and magnitude
  function automatic trig_t sine_deg(input logic [HEAD_W-1:0] t);
    trig_t      r;
    logic [6:0] k;
    logic       neg;
    if (t <= DEG_90) begin
      k   = t[6:0];
      neg = 1'b0;
    end else if (t <= DEG_180) begin
      k   = 7'(DEG_180 - t);
      neg = 1'b0;
    end else if (t <= DEG_270) begin
      k   = 7'(t - DEG_180);
      neg = 1'b1;
    end else begin
      k   = 7'(DEG_360 - t);
      neg = 1'b1;
    end
    r.mag = quarter_sine(k);
    r.neg = neg && (r.mag != '0);
    return r;
  endfunction

  // Split a wheel value into saturated forward and reverse duty
  function automatic duty_pair_t wheel_duty(input logic signed [WHEEL_W-1:0] v);
    duty_pair_t         r;
    logic [WHEEL_W-1:0] mag;
    int                 sat;
    mag   = v[WHEEL_W-1] ? WHEEL_W'(-v) : WHEEL_W'(v);
    sat   = (int'(mag) > DUTY_MAX) ? DUTY_MAX : int'(mag);
    r.fwd = '0;
    r.rev = '0;
    if (v > 0) begin
      r.fwd = DUTY_BITS'(sat);
    end else if (v < 0) begin
      r.rev = DUTY_BITS'(sat);
    end
    return r;
  endfunction

endpackage

@@ rtl/core/owdm_cmd_if.sv @@
// ----------------------------------------------------------------------------
// Omni wheel drive mixer command channel
// Heading, power and turn rate with valid/ready handshake.
// ----------------------------------------------------------------------------
interface owdm_cmd_if;
  logic                                     valid;
  logic                                     ready;
  logic        [owdm_pkg::HEAD_W-1:0]       heading_deg;
  logic        [owdm_pkg::POWER_W-1:0]      drive_power;
  logic signed [owdm_pkg::ROT_W-1:0]        turn_rate;

  modport source (output valid, heading_deg, drive_power, turn_rate, input ready);
  modport sink   (input valid, heading_deg, drive_power, turn_rate, output ready);
endinterface

@@ rtl/core/owdm_duty_if.sv @@
// ----------------------------------------------------------------------------
// Omni wheel drive mixer duty channel
// Forward and reverse duty of all four wheels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface owdm_duty_if;
  logic                             valid;
  logic                             ready;
  logic [owdm_pkg::DUTY_BITS-1:0]   back_right_fwd;
  logic [owdm_pkg::DUTY_BITS-1:0]   back_right_rev;
  logic [owdm_pkg::DUTY_BITS-1:0]   front_right_fwd;
  logic [owdm_pkg::DUTY_BITS-1:0]   front_right_rev;
  logic [owdm_pkg::DUTY_BITS-1:0]   front_left_fwd;
  logic [owdm_pkg::DUTY_BITS-1:0]   front_left_rev;
  logic [owdm_pkg::DUTY_BITS-1:0]   back_left_fwd;
  logic [owdm_pkg::DUTY_BITS-1:0]   back_left_rev;

  modport source (output valid, back_right_fwd, back_right_rev, front_right_fwd,
                  front_right_rev, front_left_fwd, front_left_rev, back_left_fwd,
                  back_left_rev, input ready);
  modport sink   (input valid, back_right_fwd, back_right_rev, front_right_fwd,
                  front_right_rev, front_left_fwd, front_left_rev, back_left_fwd,
                  back_left_rev, output ready);
endinterface

@@ rtl/core/owdm_cfg_if.sv @@
// ----------------------------------------------------------------------------
// Omni wheel drive mixer configuration channel
// Register index and write data with valid/ready handshake.
// ----------------------------------------------------------------------------
interface owdm_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [owdm_pkg::CFG_IDX_W-1:0]    index;
  logic [owdm_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/owdm_muldiv.sv @@
// ----------------------------------------------------------------------------
// Omni wheel drive mixer bit-serial multiply/divide
// Computes floor(power * num / den) one bit per cycle: shift-add multiply
// over the power bits, then restoring division for the quotient bits.
// ----------------------------------------------------------------------------
module owdm_muldiv (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [owdm_pkg::POWER_W-1:0]       power_i,
  input  logic [owdm_pkg::TRIG_W-1:0]        num_i,
  input  logic [owdm_pkg::TRIG_W-1:0]        den_i,
  output logic                               done_o,
  output logic [owdm_pkg::POWER_W-1:0]       quo_o
);

  localparam logic [owdm_pkg::CNT_W-1:0] CNT_LAST = owdm_pkg::CNT_W'(owdm_pkg::POWER_W - 1);

  logic                              busy_q, busy_d;
  logic                              div_q, div_d;
  logic                              done_q, done_d;
  logic [owdm_pkg::CNT_W-1:0]        cnt_q, cnt_d;
  logic [owdm_pkg::POWER_W-1:0]      pbits_q, pbits_d;
  logic [owdm_pkg::TRIG_W-1:0]       num_q, num_d;
  logic [owdm_pkg::PROD_W-1:0]       acc_q, acc_d;
  logic [owdm_pkg::PROD_W-1:0]       dsh_q, dsh_d;
  logic [owdm_pkg::POWER_W-1:0]      quo_q, quo_d;

  // Sequence the multiply then divide phases
  always_comb begin
    busy_d  = busy_q;
    div_d   = div_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    pbits_d = pbits_q;
    num_d   = num_q;
    acc_d   = acc_q;
    dsh_d   = dsh_q;
    quo_d   = quo_q;
    if (start_i) begin
      busy_d  = 1'b1;
      div_d   = 1'b0;
      cnt_d   = '0;
      pbits_d = power_i;
      num_d   = num_i;
      acc_d   = '0;
      dsh_d   = owdm_pkg::PROD_W'(den_i) << (owdm_pkg::POWER_W - 1);
      quo_d   = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + 1'b1;
      if (!div_q) begin
        // Shift in one multiplier bit, MSB first
        acc_d   = (acc_q << 1) +
                  (pbits_q[owdm_pkg::POWER_W-1] ? owdm_pkg::PROD_W'(num_q) : '0);
        pbits_d = pbits_q << 1;
      end else begin
        // Develop one quotient bit
        if (acc_q >= dsh_q) begin
          acc_d = acc_q - dsh_q;
          quo_d = {quo_q[owdm_pkg::POWER_W-2:0], 1'b1};
        end else begin
          quo_d = {quo_q[owdm_pkg::POWER_W-2:0], 1'b0};
        end
        dsh_d = dsh_q >> 1;
      end
      if (cnt_q == CNT_LAST) begin
        cnt_d = '0;
        div_d = ~div_q;
        if (div_q) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      div_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      div_q  <= div_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    pbits_q <= pbits_d;
    num_q   <= num_d;
    acc_q   <= acc_d;
    dsh_q   <= dsh_d;
    quo_q   <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

@@ rtl/core/owdm_spin.sv @@
// ----------------------------------------------------------------------------
// Omni wheel drive mixer spin term
// Proportional plus damping term for spin-in-place, clamped in two stages.
// ----------------------------------------------------------------------------
module owdm_spin (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [owdm_pkg::ROT_W-1:0]   rot_i,
  input  logic signed [owdm_pkg::ROT_W-1:0]   last_i,
  input  owdm_pkg::spin_cfg_t                 cfg_i,
  output logic                                done_o,
  output logic signed [owdm_pkg::ROT_W-1:0]   total_o
);

  logic signed [14:0] prop_raw;
  logic signed [14:0] lim_s;
  logic signed [9:0]  diff;
  logic signed [9:0]  half_w;
  logic signed [16:0] damp_raw;
  logic signed [17:0] sum;
  logic signed [17:0] olim_s;

  logic               s1_q;
  logic               done_q;
  logic signed [8:0]  prop_q, prop_d;
  logic signed [16:0] damp_q;
  logic signed [8:0]  total_q, total_d;

  // Stage one: clamp proportional term, halve change of rate and scale it
  always_comb begin
    prop_raw = $signed(rot_i) * $signed({1'b0, cfg_i.spin_gain});
    lim_s    = $signed({7'b0, cfg_i.spin_limit});
    if (prop_raw > lim_s) begin
      prop_d = 9'(lim_s);
    end else if (prop_raw < -lim_s) begin
      prop_d = 9'(-lim_s);
    end else begin
      prop_d = 9'(prop_raw);
    end
    diff     = 10'(rot_i) - 10'(last_i);
    half_w   = (diff + (diff[9] ? 10'sd1 : 10'sd0)) >>> 1;
    damp_raw = $signed(half_w[8:0]) * $signed({1'b0, cfg_i.damping_gain});
  end

  // Stage two: sum and clamp to the output limit
  always_comb begin
    sum    = 18'(prop_q) + 18'(damp_q);
    olim_s = $signed({10'b0, cfg_i.spin_out_limit});
    if (sum > olim_s) begin
      total_d = 9'(olim_s);
    end else if (sum < -olim_s) begin
      total_d = 9'(-olim_s);
    end else begin
      total_d = 9'(sum);
    end
  end

  // Stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      s1_q   <= start_i;
      done_q <= s1_q;
    end
  end

  // Stage payload
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prop_q <= prop_d;
      damp_q <= damp_raw;
    end
    if (s1_q) begin
      total_q <= total_d;
    end
  end

  assign done_o  = done_q;
  assign total_o = total_q;

endmodule

@@ rtl/core/omni_wheel_drive_mixer.sv @@
// ----------------------------------------------------------------------------
// Omni wheel drive mixer top level
// Turns heading, power and turn rate into forward/reverse duty for four wheels.
// ----------------------------------------------------------------------------
// Flow: drive items pass angle fold, sine lookup, the bit-serial multiply/divide
//   (one bit per cycle), wheel mix and output load; spin items use the spin unit.
// Throughput: one item at a time; the next is accepted the cycle after the
//   result enters the output register.
// Reset: control clears, registers return to defaults, last turn rate to 0.
`include "omni_wheel_drive_mixer_assert.svh"

module omni_wheel_drive_mixer (
  input  logic         clk_i,
  input  logic         rst_ni,
  owdm_cmd_if.sink     cmd_i,
  owdm_cfg_if.sink     cfg_i,
  owdm_duty_if.source  duty_o
);

  owdm_pkg::state_e   state_q, state_d;
  owdm_pkg::spin_cfg_t cfg_q;

  // Accepted item
  logic [owdm_pkg::HEAD_W-1:0]         head_q;
  logic [owdm_pkg::POWER_W-1:0]        power_q;
  logic signed [owdm_pkg::ROT_W-1:0]   rot_q;
  logic                                spin_mode_q;
  logic signed [owdm_pkg::ROT_W-1:0]   last_q;

  // Angle and trig
  logic [owdm_pkg::HEAD_W-1:0]  ang_a;
  logic [owdm_pkg::HEAD_W-1:0]  ang_t;
  logic [owdm_pkg::HEAD_W-1:0]  t_q;
  logic [owdm_pkg::HEAD_W-1:0]  tc;
  owdm_pkg::trig_t              sin_w, cos_w;
  owdm_pkg::trig_t              sin_q, cos_q;
  logic                         sin_big;

  // Units
  logic                                muldiv_start;
  logic                                muldiv_done;
  logic [owdm_pkg::POWER_W-1:0]        muldiv_quo;
  logic                                spin_start;
  logic                                spin_done;
  logic signed [owdm_pkg::ROT_W-1:0]   spin_total;
  logic signed [owdm_pkg::ROT_W:0]     out_lim_s;

  // Wheel values and output
  logic signed [owdm_pkg::WHEEL_W-1:0] sv, cv, rot_w;
  logic signed [owdm_pkg::WHEEL_W-1:0] wheel_d [4];
  logic signed [owdm_pkg::WHEEL_W-1:0] wheel_q [4];
  owdm_pkg::duty_pair_t                pair [4];
  logic [owdm_pkg::DUTY_BITS-1:0]      duty_q [8];
  logic                                out_valid_q;
  logic                                load_out;

  // Fold heading into 0..359 and form t = 45 - heading
  always_comb begin
    ang_a = (head_q >= owdm_pkg::DEG_360) ? head_q - owdm_pkg::DEG_360 : head_q;
    ang_t = owdm_pkg::DEG_405 - ang_a;
    if (ang_t >= owdm_pkg::DEG_360) begin
      ang_t = ang_t - owdm_pkg::DEG_360;
    end
  end

  // Look up sine of t and of t + 90
  always_comb begin
    tc = t_q + owdm_pkg::DEG_90;
    if (tc >= owdm_pkg::DEG_360) begin
      tc = tc - owdm_pkg::DEG_360;
    end
    sin_w = owdm_pkg::sine_deg(t_q);
    cos_w = owdm_pkg::sine_deg(tc);
  end

  assign sin_big = (sin_q.mag > cos_q.mag);

  owdm_muldiv u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (muldiv_start),
    .power_i (power_q),
    .num_i   (sin_big ? cos_q.mag : sin_q.mag),
    .den_i   (sin_big ? sin_q.mag : cos_q.mag),
    .done_o  (muldiv_done),
    .quo_o   (muldiv_quo)
  );

  owdm_spin u_spin (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (spin_start),
    .rot_i   (rot_q),
    .last_i  (last_q),
    .cfg_i   (cfg_q),
    .done_o  (spin_done),
    .total_o (spin_total)
  );

  assign out_lim_s = $signed({2'b0, cfg_q.spin_out_limit});

  // Combine scaled terms with the turn rate
  always_comb begin
    rot_w = owdm_pkg::WHEEL_W'(rot_q);
    if (sin_big) begin
      sv = owdm_pkg::WHEEL_W'({1'b0, power_q});
      cv = owdm_pkg::WHEEL_W'({1'b0, muldiv_quo});
    end else begin
      sv = owdm_pkg::WHEEL_W'({1'b0, muldiv_quo});
      cv = owdm_pkg::WHEEL_W'({1'b0, power_q});
    end
    if (sin_q.neg) begin
      sv = -sv;
    end
    if (cos_q.neg) begin
      cv = -cv;
    end
    if (spin_mode_q) begin
      for (int i = 0; i < 4; i++) begin
        wheel_d[i] = owdm_pkg::WHEEL_W'(spin_total);
      end
    end else begin
      wheel_d[0] = cv + rot_w;
      wheel_d[1] = rot_w - sv;
      wheel_d[2] = sv + rot_w;
      wheel_d[3] = rot_w - cv;
    end
  end

  // Duty split per wheel
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      pair[i] = owdm_pkg::wheel_duty(wheel_q[i]);
    end
  end

  // Next state and unit launches
  always_comb begin
    state_d      = state_q;
    muldiv_start = 1'b0;
    spin_start   = 1'b0;
    load_out     = 1'b0;
    cmd_i.ready  = (state_q == owdm_pkg::ST_IDLE);
    case (state_q)
      owdm_pkg::ST_IDLE: begin
        if (cmd_i.valid) begin
          state_d = (cmd_i.heading_deg == owdm_pkg::SPIN_CODE) ?
                    owdm_pkg::ST_SPIN_GO : owdm_pkg::ST_ANGLE;
        end
      end
      owdm_pkg::ST_ANGLE:  state_d = owdm_pkg::ST_TRIG;
      owdm_pkg::ST_TRIG:   state_d = owdm_pkg::ST_LAUNCH;
      owdm_pkg::ST_LAUNCH: begin
        muldiv_start = 1'b1;
        state_d      = owdm_pkg::ST_MULDIV;
      end
      owdm_pkg::ST_MULDIV: begin
        if (muldiv_done) begin
          state_d = owdm_pkg::ST_WHEEL;
        end
      end
      owdm_pkg::ST_SPIN_GO: begin
        spin_start = 1'b1;
        state_d    = owdm_pkg::ST_SPIN;
      end
      owdm_pkg::ST_SPIN: begin
        if (spin_done) begin
          state_d = owdm_pkg::ST_WHEEL;
        end
      end
      owdm_pkg::ST_WHEEL:  state_d = owdm_pkg::ST_FINISH;
      owdm_pkg::ST_FINISH: begin
        // Load the output slot once it is free
        if (!out_valid_q || duty_o.ready) begin
          load_out = 1'b1;
          state_d  = owdm_pkg::ST_IDLE;
        end
      end
      default: state_d = owdm_pkg::ST_IDLE;
    endcase
  end

  // State, configuration and spin history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q              <= owdm_pkg::ST_IDLE;
      cfg_q.spin_gain      <= 5'd12;
      cfg_q.spin_limit     <= 8'd165;
      cfg_q.damping_gain   <= 7'd64;
      cfg_q.spin_out_limit <= 8'd180;
      last_q               <= '0;
      out_valid_q          <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid) begin
        case (cfg_i.index)
          owdm_pkg::REG_SPIN_GAIN:      cfg_q.spin_gain      <= cfg_i.data[4:0];
          owdm_pkg::REG_SPIN_LIMIT:     cfg_q.spin_limit     <= cfg_i.data[7:0];
          owdm_pkg::REG_DAMPING_GAIN:   cfg_q.damping_gain   <= cfg_i.data[6:0];
          owdm_pkg::REG_SPIN_OUT_LIMIT: cfg_q.spin_out_limit <= cfg_i.data[7:0];
          default: ;
        endcase
      end
      if (state_q == owdm_pkg::ST_WHEEL && spin_mode_q) begin
        last_q <= rot_q;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (duty_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign cfg_i.ready = 1'b1;

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.valid && cmd_i.ready) begin
      head_q      <= cmd_i.heading_deg;
      power_q     <= cmd_i.drive_power;
      rot_q       <= cmd_i.turn_rate;
      spin_mode_q <= (cmd_i.heading_deg == owdm_pkg::SPIN_CODE);
    end
    if (state_q == owdm_pkg::ST_ANGLE) begin
      t_q <= ang_t;
    end
    if (state_q == owdm_pkg::ST_TRIG) begin
      sin_q <= sin_w;
      cos_q <= cos_w;
    end
    if (state_q == owdm_pkg::ST_WHEEL) begin
      wheel_q <= wheel_d;
    end
    if (load_out) begin
      for (int i = 0; i < 4; i++) begin
        duty_q[2*i]   <= pair[i].fwd;
        duty_q[2*i+1] <= pair[i].rev;
      end
    end
  end

  // Drive the output beat
  assign duty_o.valid           = out_valid_q;
  assign duty_o.back_right_fwd  = duty_q[0];
  assign duty_o.back_right_rev  = duty_q[1];
  assign duty_o.front_right_fwd = duty_q[2];
  assign duty_o.front_right_rev = duty_q[3];
  assign duty_o.front_left_fwd  = duty_q[4];
  assign duty_o.front_left_rev  = duty_q[5];
  assign duty_o.back_left_fwd   = duty_q[6];
  assign duty_o.back_left_rev   = duty_q[7];

  // Accepted beat leaves idle along the matching path
  `OWDM_ASSERT_NEXT(a_accept_dispatch, clk_i, rst_ni, cmd_i.valid && cmd_i.ready, state_q == owdm_pkg::ST_ANGLE || state_q == owdm_pkg::ST_SPIN_GO)
  // Scaled term never exceeds the drive power
  `OWDM_ASSERT_IMPLIES(a_quo_bounded, clk_i, rst_ni, muldiv_done, muldiv_quo <= power_q)
  // Spin total stays inside the output limit
  `OWDM_ASSERT_IMPLIES(a_spin_bounded, clk_i, rst_ni, spin_done, (spin_total <= out_lim_s) && (spin_total >= -out_lim_s))

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// Omni wheel drive mixer testbench
// Sends heading/power/turn-rate beats, predicts the eight wheel duties of each
// command with a behavioral model, and checks every duty beat in order while
// both channels idle at random and the spin registers change between phases.
// ----------------------------------------------------------------------------
module testbench;

  localparam int  LIMIT_CYCLES    = 400000;
  localparam int  DRAIN_CYCLES    = 30;
  localparam int  MAX_REPORTS     = 100;
  localparam int  TABLE_FRAC_BITS = 15;
  localparam real PI              = 3.14159265358979323846;

  typedef struct packed {
    owdm_pkg::duty_pair_t back_right;
    owdm_pkg::duty_pair_t front_right;
    owdm_pkg::duty_pair_t front_left;
    owdm_pkg::duty_pair_t back_left;
  } wheel_duties_t;

  logic clk_i      = 1'b0;
  logic rst_ni     = 1'b0;
  logic recv_ready = 1'b0;

  owdm_cmd_if  cmd ();
  owdm_cfg_if  cfg ();
  owdm_duty_if duty ();

  omni_wheel_drive_mixer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .cfg_i  (cfg),
    .duty_o (duty)
  );

  // Model copy of the spin registers and the stored turn rate
  int spin_gain_q;
  int spin_limit_q;
  int damping_gain_q;
  int spin_out_limit_q;
  int last_spin_rate_q;

  int            sine_tab [91];
  wheel_duties_t pending_duties [$];

  int error_count;
  int checked_count;
  int drive_count;
  int spin_count;
  int write_count;
  int cycle_count;
  int send_idle_pct;
  int recv_idle_pct;

  always #1 clk_i = ~clk_i;

  assign duty.ready = recv_ready;

  // Stall the duty channel at the current rate
  always @(posedge clk_i) begin
    recv_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("cycle limit hit, %0d duty beats still outstanding", pending_duties.size());
      $display("[omni_wheel_drive_mixer] ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Quarter-wave sine at the working fraction width
  function automatic int trig_q(int k);
    int v;
    v = sine_tab[(k > 90) ? 90 : k];
    if (owdm_pkg::TRIG_FRAC_BITS >= TABLE_FRAC_BITS) begin
      return v << (owdm_pkg::TRIG_FRAC_BITS - TABLE_FRAC_BITS);
    end
    return (v + ((1 << (TABLE_FRAC_BITS - owdm_pkg::TRIG_FRAC_BITS)) >> 1))
           >> (TABLE_FRAC_BITS - owdm_pkg::TRIG_FRAC_BITS);
  endfunction

  // Signed sine of t whole degrees
  function automatic int sine_fixed(int t);
    t = t % 360;
    if (t <= 90) return trig_q(t);
    if (t <= 180) return trig_q(180 - t);
    if (t <= 270) return -trig_q(t - 180);
    return -trig_q(360 - t);
  endfunction

  function automatic int clamp_sym(int v, int lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Split one wheel value into saturated forward and reverse duty
  function automatic owdm_pkg::duty_pair_t split_duty(int v);
    owdm_pkg::duty_pair_t d;
    int                   mag;
    mag   = (v < 0) ? -v : v;
    mag   = (mag > owdm_pkg::DUTY_MAX) ? owdm_pkg::DUTY_MAX : mag;
    d.fwd = '0;
    d.rev = '0;
    if (v > 0) d.fwd = mag[owdm_pkg::DUTY_BITS-1:0];
    else if (v < 0) d.rev = mag[owdm_pkg::DUTY_BITS-1:0];
    return d;
  endfunction

  // Wheel duties for one command; spin commands also advance the stored rate
  function automatic wheel_duties_t predict_duties(int heading, int power, int rate);
    wheel_duties_t d;
    int            w [4];
    int            t, s, c, m, sv, cv, prop, damp, total;
    if (heading == int'(owdm_pkg::SPIN_CODE)) begin
      prop  = clamp_sym(rate * spin_gain_q, spin_limit_q);
      damp  = ((rate - last_spin_rate_q) / 2) * damping_gain_q;
      total = clamp_sym(prop + damp, spin_out_limit_q);
      last_spin_rate_q = rate;
      for (int i = 0; i < 4; i++) w[i] = total;
    end else begin
      t  = (405 - (heading % 360)) % 360;
      s  = sine_fixed(t);
      c  = sine_fixed(t + 90);
      m  = ((s < 0 ? -s : s) > (c < 0 ? -c : c)) ? (s < 0 ? -s : s) : (c < 0 ? -c : c);
      sv = (power * (s < 0 ? -s : s)) / m;
      cv = (power * (c < 0 ? -c : c)) / m;
      if (s < 0) sv = -sv;
      if (c < 0) cv = -cv;
      w[0] = cv + rate;
      w[1] = -sv + rate;
      w[2] = sv + rate;
      w[3] = -cv + rate;
    end
    d.back_right  = split_duty(w[0]);
    d.front_right = split_duty(w[1]);
    d.front_left  = split_duty(w[2]);
    d.back_left   = split_duty(w[3]);
    return d;
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  // Count a failure; print only the first batch to keep the log short
  task automatic report(string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("mismatch %0d: %s", error_count, msg);
  endtask

  task automatic check_field(string name, logic [owdm_pkg::DUTY_BITS-1:0] got,
                             logic [owdm_pkg::DUTY_BITS-1:0] want);
    if (got !== want) begin
      report($sformatf("beat %0d %s: got %0d, expected %0d", checked_count, name, got, want));
    end
  endtask

  // Compare each duty beat with the oldest prediction
  always @(posedge clk_i) begin
    wheel_duties_t want;
    if (rst_ni && duty.valid && duty.ready) begin
      if (pending_duties.size() == 0) begin
        report("duty beat with no command outstanding");
      end else begin
        want = pending_duties.pop_front();
        check_field("back_right_fwd", duty.back_right_fwd, want.back_right.fwd);
        check_field("back_right_rev", duty.back_right_rev, want.back_right.rev);
        check_field("front_right_fwd", duty.front_right_fwd, want.front_right.fwd);
        check_field("front_right_rev", duty.front_right_rev, want.front_right.rev);
        check_field("front_left_fwd", duty.front_left_fwd, want.front_left.fwd);
        check_field("front_left_rev", duty.front_left_rev, want.front_left.rev);
        check_field("back_left_fwd", duty.back_left_fwd, want.back_left.fwd);
        check_field("back_left_rev", duty.back_left_rev, want.back_left.rev);
        checked_count++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Send one command beat, idling first at the current rate
  task automatic send_command(int heading, int power, int rate);
    logic        [owdm_pkg::HEAD_W-1:0]  h;
    logic        [owdm_pkg::POWER_W-1:0] p;
    logic signed [owdm_pkg::ROT_W-1:0]   r;
    h = heading[owdm_pkg::HEAD_W-1:0];
    p = power[owdm_pkg::POWER_W-1:0];
    r = rate[owdm_pkg::ROT_W-1:0];
    while ($urandom_range(99) < send_idle_pct) begin
      cmd.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd.valid       <= 1'b1;
    cmd.heading_deg <= h;
    cmd.drive_power <= p;
    cmd.turn_rate   <= r;
    @(posedge clk_i);
    while (!cmd.ready) @(posedge clk_i);
    pending_duties.push_back(predict_duties(int'(h), int'(p), int'(r)));
    if (h == owdm_pkg::SPIN_CODE) spin_count++;
    else drive_count++;
  endtask

  // Drop valid and hold until every predicted duty beat has arrived
  task automatic wait_for_duties();
    cmd.valid <= 1'b0;
    do @(posedge clk_i); while (pending_duties.size() != 0);
  endtask

  // Write one register beat; leaves valid high for a following beat
  task automatic write_register(logic [owdm_pkg::CFG_IDX_W-1:0] index,
                                logic [owdm_pkg::CFG_DATA_W-1:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= index;
    cfg.data  <= value;
    @(posedge clk_i);
    while (!cfg.ready) @(posedge clk_i);
    case (index)
      owdm_pkg::REG_SPIN_GAIN:      spin_gain_q      = int'(value[4:0]);
      owdm_pkg::REG_SPIN_LIMIT:     spin_limit_q     = int'(value);
      owdm_pkg::REG_DAMPING_GAIN:   damping_gain_q   = int'(value[6:0]);
      owdm_pkg::REG_SPIN_OUT_LIMIT: spin_out_limit_q = int'(value);
      default: ;
    endcase
    write_count++;
  endtask

  // Load all four spin registers, then poke an unused index
  task automatic program_registers(logic [7:0] gain, logic [7:0] limit,
                                   logic [7:0] damping, logic [7:0] out_limit);
    logic [31:0] rnd;
    write_register(owdm_pkg::REG_SPIN_GAIN, gain);
    write_register(owdm_pkg::REG_SPIN_LIMIT, limit);
    write_register(owdm_pkg::REG_DAMPING_GAIN, damping);
    write_register(owdm_pkg::REG_SPIN_OUT_LIMIT, out_limit);
    rnd = $urandom_range(255, 4);
    write_register(rnd[owdm_pkg::CFG_IDX_W-1:0], 8'($urandom));
    cfg.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Cardinal and diagonal headings, wrapped headings, zero power, rate extremes
  task automatic test_drive_directed();
    send_command(0, 255, 0);
    send_command(45, 255, 0);
    send_command(90, 200, 10);
    send_command(135, 255, -255);
    send_command(180, 1, 255);
    send_command(225, 128, -256);
    send_command(270, 255, 255);
    send_command(315, 77, -1);
    send_command(359, 255, 0);
    send_command(360, 100, 0);
    send_command(405, 255, 0);
    send_command(499, 255, -100);
    send_command(501, 200, 50);
    send_command(511, 255, 0);
    send_command(30, 0, -256);
    send_command(0, 0, 0);
    wait_for_duties();
  endtask

  // Spin from reset state under default registers; power must be ignored
  task automatic test_spin_directed();
    send_command(int'(owdm_pkg::SPIN_CODE), 255, 255);
    send_command(int'(owdm_pkg::SPIN_CODE), 0, -256);
    send_command(int'(owdm_pkg::SPIN_CODE), 17, -255);
    send_command(int'(owdm_pkg::SPIN_CODE), 255, 0);
    send_command(int'(owdm_pkg::SPIN_CODE), 3, 1);
    send_command(int'(owdm_pkg::SPIN_CODE), 99, -1);
    send_command(int'(owdm_pkg::SPIN_CODE), 200, 100);
    wait_for_duties();
  endtask

  // One random command: spin-heavy mix, small rates often, power extremes
  task automatic send_random_command();
    int heading, power, rate, pick;
    pick    = $urandom_range(99);
    heading = (pick < 40) ? int'(owdm_pkg::SPIN_CODE) : int'($urandom_range(511));
    pick    = $urandom_range(9);
    power   = (pick == 0) ? 0 : (pick == 1) ? 255 : int'($urandom_range(255));
    pick    = $urandom_range(5);
    if (pick < 2) rate = int'($urandom_range(40)) - 20;
    else if (pick == 2) rate = ($urandom_range(1) != 0) ? 255 : -256;
    else rate = int'($urandom_range(511)) - 256;
    send_command(heading, power, rate);
  endtask

  // Random traffic at one idle mix, under four register settings in turn
  task automatic test_random_traffic(int items, int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int setting = 0; setting < 4; setting++) begin
      case (setting)
        0: program_registers(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        1: program_registers(8'h00, 8'h00, 8'h00, 8'h00);
        2: program_registers(8'd12, 8'd165, 8'd64, 8'd180);
        default: program_registers(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      endcase
      for (int n = 0; n < items / 4; n++) send_random_command();
      wait_for_duties();
    end
  endtask

  initial begin
    for (int k = 0; k <= 90; k++) begin
      sine_tab[k] = $rtoi($sin(k * PI / 180.0) * real'(1 << TABLE_FRAC_BITS) + 0.5);
    end
    cmd.valid        = 1'b0;
    cmd.heading_deg  = '0;
    cmd.drive_power  = '0;
    cmd.turn_rate    = '0;
    cfg.valid        = 1'b0;
    cfg.index        = '0;
    cfg.data         = '0;
    spin_gain_q      = 12;
    spin_limit_q     = 165;
    damping_gain_q   = 64;
    spin_out_limit_q = 180;
    last_spin_rate_q = 0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_drive_directed();
    test_spin_directed();
    test_random_traffic(400, 20, 47);
    test_random_traffic(400, 47, 20);
    test_random_traffic(400, 0, 0);

    wait_for_duties();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("ran %0d drive and %0d spin commands over %0d register writes, three idle mixes",
             drive_count, spin_count, write_count);
    $display("checked %0d duty beats, %0d mismatches", checked_count, error_count);
    if (error_count == 0 && pending_duties.size() == 0) begin
      $display("[omni_wheel_drive_mixer] OK");
    end else begin
      $display("[omni_wheel_drive_mixer] ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/owdm_pkg.sv
rtl/core/owdm_cmd_if.sv
rtl/core/owdm_duty_if.sv
rtl/core/owdm_cfg_if.sv
rtl/core/owdm_muldiv.sv
rtl/core/owdm_spin.sv
rtl/core/omni_wheel_drive_mixer.sv
sim/testbench.sv
